FILE: rtl/core/ucc_pkg.sv
`timescale 1ns / 1ps
// Package for the UTF-8 case converter: result group type, kind codes and
// the byte-level case mapping functions. No dependencies.
package ucc_pkg;

  localparam logic [7:0] LEAD_MIN = 8'hc0;
  localparam logic [7:0] LEAD_E1  = 8'he1;
  localparam logic [7:0] LEAD_F0  = 8'hf0;
  localparam logic [7:0] F0_OSAGE = 8'h90;
  localparam logic [7:0] F0_ADLAM = 8'h9e;

  typedef logic [2:0] kind_t;
  localparam kind_t K_RAW   = 3'd0;
  localparam kind_t K_ASCII = 3'd1;
  localparam kind_t K_MAP2  = 3'd2;
  localparam kind_t K_MAP3  = 3'd3;
  localparam kind_t K_MAP4  = 3'd4;

  typedef struct packed {
    kind_t           kind;
    logic            up;
    logic            last;
    logic [1:0]      lidx;
    logic [3:0][7:0] bytes;
  } group_t;

  function automatic logic [15:0] up2(input logic [7:0] l, input logic [7:0] c);
    logic [7:0] ln;
    logic [7:0] cn;
    logic       o;
    begin
      ln = l; cn = c; o = c[0];
      case (l)
        8'hc3: if (c inside {[8'ha0:8'hbe]} && c != 8'hb7) cn = c - 8'h20;
        8'hc4: if ((c inside {[8'h80:8'hb7]} && o) || (c inside {[8'hb9:8'hbe]} && !o))
          cn = c - 8'h01;
        8'hc5: begin
          if (c == 8'h80) begin ln = 8'hc4; cn = 8'hbf; end
          else if ((c inside {[8'h82:8'h88]} && !o) || (c inside {[8'h8a:8'hb7]} && o) ||
                   (c inside {[8'hb9:8'hbe]} && !o)) cn = c - 8'h01;
        end
        8'hc6: if (c inside {8'h83, 8'h85, 8'h88, 8'h8c, 8'h92, 8'h99, 8'ha1, 8'ha3,
                             8'ha5, 8'ha8, 8'had, 8'hb0, 8'hb4, 8'hb6, 8'hb9, 8'hbd})
          cn = c - 8'h01;
        8'hc7: begin
          if (c inside {8'h86, 8'h89, 8'h8c, 8'hb3}) cn = c - 8'h02;
          else if (c inside {8'h85, 8'h88, 8'h8b, 8'hb2, 8'hb5, 8'hb9, 8'hbb, 8'hbd, 8'hbf})
            cn = c - 8'h01;
          else if ((c inside {[8'h8d:8'h9c]} && !o) || (c inside {[8'h9e:8'haf]} && o))
            cn = c - 8'h01;
        end
        8'hc8: if ((c inside {[8'h80:8'h9f]} && o) || (c inside {[8'ha2:8'hb3]} && o) ||
                   c == 8'hbc) cn = c - 8'h01;
        8'hcd: begin
          if (c inside {8'hb1, 8'hb3, 8'hb7}) cn = c - 8'h01;
          else if (c inside {[8'hbb:8'hbd]}) begin ln = 8'hcf; cn = c + 8'h02; end
        end
        8'hce: begin
          if (c == 8'hac) cn = 8'h86;
          else if (c inside {[8'had:8'haf]}) cn = c - 8'h25;
          else if (c inside {[8'hb1:8'hbf]}) cn = c - 8'h20;
        end
        8'hcf: begin
          if (c == 8'h97) cn = 8'h8f;
          else if (c == 8'h91) begin ln = 8'hce; cn = 8'h98; end
          else if ((c inside {[8'h98:8'haf]} && o) || c == 8'hb8 || c == 8'hbb) cn = c - 8'h01;
          else if (c == 8'hb2) cn = 8'hb9;
          else if (c == 8'h8c) ln = 8'hce;
          else if (c == 8'h8d || c == 8'h8e) begin ln = 8'hce; cn = c + 8'h01; end
          else if (c inside {[8'h80:8'h8b]} && c != 8'h82) begin ln = 8'hce; cn = c + 8'h20; end
          else if (c == 8'hb3) begin ln = 8'hcd; cn = 8'hbf; end
        end
        8'hd0: if (c inside {[8'hb0:8'hbf]}) cn = c - 8'h20;
        8'hd1: begin
          if (c inside {[8'h80:8'h8f]}) begin ln = 8'hd0; cn = c + 8'h20; end
          else if (c inside {[8'h90:8'h9f]}) begin ln = 8'hd0; cn = c - 8'h10; end
          else if (c inside {[8'ha0:8'hbf]} && o) cn = c - 8'h01;
        end
        8'hd2: begin
          if (c == 8'h81) cn = 8'h80;
          else if (c inside {[8'h8a:8'hbf]} && o) cn = c - 8'h01;
        end
        8'hd3: if ((c inside {[8'h81:8'h8e]} && !o) || (c inside {[8'h90:8'hbf]} && o))
          cn = c - 8'h01;
        8'hd4: if (c inside {[8'h80:8'haf]} && o) cn = c - 8'h01;
        8'hd5: begin
          if (c inside {[8'ha1:8'haf]}) begin ln = 8'hd4; cn = c + 8'h10; end
          else if (c inside {[8'hb0:8'hbf]}) cn = c - 8'h30;
        end
        8'hd6: if (c inside {[8'h80:8'h86]}) begin ln = 8'hd5; cn = c + 8'h10; end
        default: ;
      endcase
      return {ln, cn};
    end
  endfunction

  function automatic logic [15:0] lo2(input logic [7:0] l, input logic [7:0] c);
    logic [7:0] ln;
    logic [7:0] cn;
    logic [7:0] cp;
    logic       o;
    begin
      ln = l; cn = c; o = c[0]; cp = c + 8'h01;
      case (l)
        8'hc3: if (c inside {[8'h80:8'h9e]} && c != 8'h97) cn = c + 8'h20;
        8'hc4: begin
          if ((c inside {[8'h80:8'hb7]} && !o) || (c inside {[8'hb9:8'hbe]} && o)) cn = cp;
          else if (c == 8'hbf) begin ln = 8'hc5; cn = 8'h80; end
        end
        8'hc5: if ((c inside {[8'h81:8'h88]} && o) || (c inside {[8'h8a:8'hb7]} && !o) ||
                   (c inside {[8'hb9:8'hbe]} && o)) cn = cp;
        8'hc6: if (cp inside {8'h83, 8'h85, 8'h88, 8'h8c, 8'h92, 8'h99, 8'ha1, 8'ha3,
                              8'ha5, 8'ha8, 8'had, 8'hb0, 8'hb4, 8'hb6, 8'hb9, 8'hbd})
          cn = cp;
        8'hc7: begin
          if (c inside {8'h84, 8'h87, 8'h8a, 8'hb1}) cn = c + 8'h02;
          else if (c inside {8'h85, 8'h88, 8'h8b, 8'hb2, 8'hb4, 8'hb8, 8'hba, 8'hbc, 8'hbe})
            cn = cp;
          else if ((c inside {[8'h8d:8'h9c]} && o) || (c inside {[8'h9e:8'haf]} && !o))
            cn = cp;
        end
        8'hc8: if ((c inside {[8'h80:8'h9f]} && !o) || (c inside {[8'ha2:8'hb3]} && !o) ||
                   c == 8'hbb) cn = cp;
        8'hcd: begin
          if (c inside {8'hb0, 8'hb2, 8'hb6}) cn = cp;
          else if (c == 8'hbf) begin ln = 8'hcf; cn = 8'hb3; end
        end
        8'hce: begin
          if (c == 8'h86) cn = 8'hac;
          else if (c inside {[8'h88:8'h8a]}) cn = c + 8'h25;
          else if (c == 8'h8c) ln = 8'hcf;
          else if (c == 8'h8e || c == 8'h8f) begin ln = 8'hcf; cn = c - 8'h01; end
          else if (c inside {[8'h91:8'h9f]}) cn = c + 8'h20;
          else if (c inside {[8'ha0:8'hab]} && c != 8'ha2) begin ln = 8'hcf; cn = c - 8'h20; end
        end
        8'hcf: begin
          if (c == 8'h8f) cn = 8'h97;
          else if ((c inside {[8'h98:8'haf]} && !o) || c == 8'hb7 || c == 8'hba) cn = cp;
          else if (c == 8'hb9) cn = 8'hb2;
          else if (c inside {[8'hbd:8'hbf]}) begin ln = 8'hcd; cn = c - 8'h02; end
        end
        8'hd0: begin
          if (c inside {[8'h80:8'h8f]}) begin ln = 8'hd1; cn = c + 8'h10; end
          else if (c inside {[8'h90:8'h9f]}) cn = c + 8'h20;
          else if (c inside {[8'ha0:8'haf]}) begin ln = 8'hd1; cn = c - 8'h20; end
        end
        8'hd1: if (c inside {[8'ha0:8'hbf]} && !o) cn = cp;
        8'hd2: begin
          if (c == 8'h80) cn = 8'h81;
          else if (c inside {[8'h8a:8'hbf]} && !o) cn = cp;
        end
        8'hd3: if ((c inside {[8'h81:8'h8d]} && o) || (c inside {[8'h90:8'hbf]} && !o)) cn = cp;
        8'hd4: begin
          if (c inside {[8'h80:8'haf]} && !o) cn = cp;
          else if (c inside {[8'hb1:8'hbf]}) begin ln = 8'hd5; cn = c - 8'h10; end
        end
        8'hd5: begin
          if (c inside {[8'h80:8'h8f]}) cn = c + 8'h30;
          else if (c inside {[8'h90:8'h96]}) begin ln = 8'hd6; cn = c - 8'h10; end
        end
        default: ;
      endcase
      return {ln, cn};
    end
  endfunction

  function automatic logic [15:0] up3(input logic [7:0] s, input logic [7:0] c);
    logic [7:0] sn;
    logic [7:0] cn;
    begin
      sn = s; cn = c;
      case (s)
        8'h83: begin
          if (c inside {[8'h90:8'haf]}) begin sn = 8'h82; cn = c + 8'h10; end
          else if (c inside {[8'hb0:8'hb5], 8'hb7, 8'hbd}) cn = c - 8'h30;
        end
        8'hb8, 8'hb9, 8'hbb: if (c inside {[8'h80:8'hbf]} && c[0]) cn = c - 8'h01;
        8'hba: if (c inside {[8'h80:8'h95], [8'ha0:8'hbf]} && c[0]) cn = c - 8'h01;
        8'hbc, 8'hbd: if (c inside {[8'h80:8'hbf]} && !c[3]) cn = c + 8'h08;
        8'hbe: if (c inside {[8'h80:8'hb1]} && !c[3]) cn = c + 8'h08;
        8'hbf: if (c inside {[8'h80:8'h84], [8'h90:8'h93], [8'ha0:8'ha4]}) cn = c + 8'h08;
        default: ;
      endcase
      return {sn, cn};
    end
  endfunction

  function automatic logic [15:0] lo3(input logic [7:0] s, input logic [7:0] c);
    logic [7:0] sn;
    logic [7:0] cn;
    begin
      sn = s; cn = c;
      case (s)
        8'h82: if (c inside {[8'ha0:8'hbf]}) begin sn = 8'h83; cn = c - 8'h10; end
        8'h83: if (c inside {[8'h80:8'h85], 8'h87, 8'h8d}) cn = c + 8'h30;
        8'hb8, 8'hb9, 8'hbb: if (c inside {[8'h80:8'hbf]} && !c[0]) cn = c + 8'h01;
        8'hba: if (c inside {[8'h80:8'h95], [8'ha0:8'hbf]} && !c[0]) cn = c + 8'h01;
        8'hbc, 8'hbd: if (c inside {[8'h80:8'hbf]} && c[3]) cn = c - 8'h08;
        8'hbe: if (c inside {[8'h80:8'hb9]} && c[3]) cn = c - 8'h08;
        8'hbf: if (c inside {[8'h88:8'h8c], [8'h98:8'h9b], [8'ha8:8'hac]}) cn = c - 8'h08;
        default: ;
      endcase
      return {sn, cn};
    end
  endfunction

  function automatic logic [15:0] map4(input logic up, input logic [7:0] s,
                                       input logic [7:0] t, input logic [7:0] c);
    logic [7:0] tn;
    logic [7:0] cn;
    begin
      tn = t; cn = c;
      if (s == F0_OSAGE) begin
        if (up) begin
          if (t == 8'h93 && c inside {[8'h98:8'ha7]}) begin tn = 8'h92; cn = c + 8'h18; end
          else if (t == 8'h93 && c inside {[8'ha8:8'hbb]}) cn = c - 8'h28;
        end else begin
          if (t == 8'h92 && c inside {[8'hb0:8'hbf]}) begin tn = 8'h93; cn = c - 8'h18; end
          else if (t == 8'h93 && c inside {[8'h80:8'h93]}) cn = c + 8'h28;
        end
      end else if (s == F0_ADLAM) begin
        if (up) begin
          if (t == 8'ha4 && c inside {[8'ha2:8'hbf]}) cn = c - 8'h22;
          else if (t == 8'ha5 && c inside {[8'h80:8'h83]}) begin tn = 8'ha4; cn = c + 8'h1e; end
        end else begin
          if (t == 8'ha4 && c inside {[8'h80:8'h9d]}) cn = c + 8'h22;
          else if (t == 8'ha4 && c inside {[8'h9e:8'ha1]}) begin tn = 8'ha5; cn = c - 8'h1e; end
        end
      end
      return {tn, cn};
    end
  endfunction

  function automatic logic [3:0][7:0] map_group(input group_t g);
    logic [3:0][7:0] b;
    logic [15:0]     r;
    begin
      b = g.bytes;
      r = 16'h0000;
      case (g.kind)
        K_ASCII: begin
          if (g.up && b[0] inside {[8'h61:8'h7a]}) b[0] = b[0] - 8'h20;
          else if (!g.up && b[0] inside {[8'h41:8'h5a]}) b[0] = b[0] + 8'h20;
        end
        K_MAP2: begin
          r = g.up ? up2(b[0], b[1]) : lo2(b[0], b[1]);
          b[0] = r[15:8]; b[1] = r[7:0];
        end
        K_MAP3: begin
          r = g.up ? up3(b[1], b[2]) : lo3(b[1], b[2]);
          b[1] = r[15:8]; b[2] = r[7:0];
        end
        K_MAP4: begin
          r = map4(g.up, b[1], b[2], b[3]);
          b[2] = r[15:8]; b[3] = r[7:0];
        end
        default: ;
      endcase
      return b;
    end
  endfunction

endpackage

FILE: rtl/core/ucc_front.sv
`timescale 1ns / 1ps
// Front end: takes bytes, holds open sequences and classifies complete groups.
// Depends on ucc_pkg.
module ucc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            acc,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            enq,
  output ucc_pkg::group_t grp
);
  import ucc_pkg::*;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_TWO  = 3'd1;
  localparam logic [2:0] P_E1   = 3'd2;
  localparam logic [2:0] P_E1S  = 3'd3;
  localparam logic [2:0] P_F0   = 3'd4;
  localparam logic [2:0] P_F0S  = 3'd5;
  localparam logic [2:0] P_F0T  = 3'd6;

  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] path_r, path_nxt;
  logic       stop_r, stop_nxt;
  logic       up_r;
  logic       fin;

  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    path_nxt = path_r;
    stop_nxt = stop_r;
    enq      = 1'b0;
    fin      = 1'b0;
    for (int k = 0; k < 3; k++) begin
      grp.bytes[k] = (2'(k) < cnt_r) ? held_r[k] : in_byte;
    end
    grp.bytes[3] = in_byte;
    grp.lidx     = cnt_r;
    grp.last     = in_last;
    grp.up       = up_r;
    grp.kind     = K_RAW;
    if (acc) begin
      if (stop_r || path_r == P_IDLE) begin
        path_nxt = P_IDLE;
        cnt_nxt  = 2'd0;
        if (!stop_r && in_byte == 8'h00) begin
          // a zero that also ends the string leaves the next string live
          stop_nxt = !in_last;
          enq      = 1'b1;
        end else if (!stop_r && in_byte > LEAD_MIN && !in_last) begin
          // open a sequence; the lead picks its length
          held_nxt[0] = in_byte;
          cnt_nxt     = 2'd1;
          path_nxt    = (in_byte == LEAD_E1) ? P_E1 : (in_byte == LEAD_F0) ? P_F0 : P_TWO;
        end else begin
          enq = 1'b1;
          if (!stop_r) grp.kind = K_ASCII;
          if (in_last) stop_nxt = 1'b0;
        end
      end else begin
        case (path_r)
          P_TWO: begin grp.kind = K_MAP2; fin = 1'b1; end
          P_E1S: begin grp.kind = K_MAP3; fin = 1'b1; end
          P_F0S: fin = (held_r[1] != F0_OSAGE) && (held_r[1] != F0_ADLAM);
          P_F0T: begin grp.kind = K_MAP4; fin = 1'b1; end
          default: ;
        endcase
        if (in_last || cnt_r == 2'd3) fin = 1'b1;
        if (fin) begin
          enq      = 1'b1;
          path_nxt = P_IDLE;
          cnt_nxt  = 2'd0;
          if (in_last) stop_nxt = 1'b0;
        end else begin
          held_nxt[cnt_r] = in_byte;
          cnt_nxt         = cnt_r + 2'd1;
          path_nxt        = path_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      path_r <= P_IDLE;
      stop_r <= 1'b0;
      up_r   <= 1'b1;
    end else begin
      cnt_r  <= cnt_nxt;
      path_r <= path_nxt;
      stop_r <= stop_nxt;
      if (cfg_we) up_r <= cfg_wdata;
    end
  end

  a_open_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    path_r != P_IDLE |-> !stop_r) else $error("sequence open while stopped");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    path_r == P_IDLE |-> cnt_r == 2'd0) else $error("held bytes without sequence");

endmodule

FILE: rtl/core/ucc_queue.sv
`timescale 1ns / 1ps
// Short group queue between front and back end.
// Depends on ucc_pkg.
module ucc_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ucc_pkg::group_t wdata,
  output logic            full,
  input  logic            pop,
  output ucc_pkg::group_t rdata,
  output logic            empty
);
  import ucc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t        mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push && !full) wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop && !empty) rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count beyond depth");

endmodule

FILE: rtl/core/ucc_back.sv
`timescale 1ns / 1ps
// Back end: maps one group and hands its bytes out one per cycle while pop is high.
// Depends on ucc_pkg.
module ucc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  ucc_pkg::group_t q_rdata,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            out_run_end,
  output logic            out_string_end
);
  import ucc_pkg::*;

  logic [3:0][7:0] bytes_r;
  logic [1:0]      lidx_r, idx_r;
  logic            last_r, valid_r;
  logic            done;

  assign done           = valid_r && pop && (idx_r == lidx_r);
  assign q_pop          = (!valid_r || done) && !q_empty;
  assign empty          = !valid_r;
  assign out_byte       = bytes_r[idx_r];
  assign out_run_end    = (idx_r == lidx_r);
  assign out_string_end = out_run_end && last_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bytes_r <= map_group(q_rdata);
      lidx_r  <= q_rdata.lidx;
      last_r  <= q_rdata.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (done) begin
      valid_r <= 1'b0;
    end else if (pop && valid_r) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

FILE: rtl/core/utf8_case_converter.sv
`timescale 1ns / 1ps
// UTF-8 case converter, top level. A byte that completes a group is written to
// the queue at the edge that takes it and is then loaded into the back register,
// from which its first result can be popped once the back end is free.
// Takes one input byte per cycle while full is low; groups leave one byte per pop.
// Reset (rst_n low, synchronous) empties queue and back end, closes any open
// sequence, clears the stop flag and sets the mode to uppercase.
// Depends on ucc_pkg, ucc_front, ucc_queue, ucc_back.
module utf8_case_converter #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_string_end
);
  import ucc_pkg::*;

  logic   acc;
  logic   enq;
  group_t grp;
  group_t q_rdata;
  logic   q_empty;
  logic   q_pop;

  // take a request whenever the queue has room; the front never stalls otherwise
  assign acc = push && !full;

  // front: hold lead bytes until the sequence is complete, then tag the group
  ucc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .enq       (enq),
    .grp       (grp)
  );

  // decouple: front keeps taking bytes while the back end drains a long group
  ucc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (enq),
    .wdata (grp),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: rewrite the group and advance one byte per accepted pop
  ucc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

  a_mid_group: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_run_end) |=> !empty)
    else $error("result group broken off");
  a_str_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_string_end) |-> out_run_end)
    else $error("string end off a group boundary");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_case_converter: drives UTF-8 strings through
// the push/full side, predicts every converted byte and checks the pop side.
// Depends on the RTL (ucc_pkg and the converter top level).
module tb_top;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_run_end;
  logic       out_string_end;

  // One expected output byte with its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } conv_byte_t;

  // Paths of an open multibyte sequence.
  typedef enum logic [2:0] {
    P_NONE    = 3'd0,
    P_TWO     = 3'd1,
    P_E1      = 3'd2,
    P_E1_MID  = 3'd3,
    P_F0      = 3'd4,
    P_F0_MID  = 3'd5,
    P_F0_TAIL = 3'd6
  } seq_path_e;

  localparam logic [7:0] OSAGE_2ND = 8'h90;
  localparam logic [7:0] ADLAM_2ND = 8'h9e;

  conv_byte_t expected_bytes[$];
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  // Predictor state.
  logic [7:0] held[3];
  int         held_n = 0;
  seq_path_e  path = P_NONE;
  logic       stopped = 1'b0;
  logic       mode_upper = 1'b1;

  utf8_case_converter dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .in_byte(in_byte), .in_last(in_last),
    .pop(pop), .empty(empty), .out_byte(out_byte), .out_run_end(out_run_end),
    .out_string_end(out_string_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit in_rng(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic bit c6_list(logic [7:0] c);
    return c == 8'h83 || c == 8'h85 || c == 8'h88 || c == 8'h8c || c == 8'h92 ||
           c == 8'h99 || c == 8'ha1 || c == 8'ha3 || c == 8'ha5 || c == 8'ha8 ||
           c == 8'had || c == 8'hb0 || c == 8'hb4 || c == 8'hb6 || c == 8'hb9 ||
           c == 8'hbd;
  endfunction

  // Two-byte uppercase rules.
  function automatic void upper2(inout logic [7:0] l, inout logic [7:0] c);
    logic o;
    o = c[0];
    case (l)
      8'hc3: if (in_rng(c, 8'ha0, 8'hbe) && c != 8'hb7) c -= 8'h20;
      8'hc4: if ((in_rng(c, 8'h80, 8'hb7) && o) || (in_rng(c, 8'hb9, 8'hbe) && !o)) c--;
      8'hc5:
        if (c == 8'h80) begin l = 8'hc4; c = 8'hbf; end
        else if ((in_rng(c, 8'h82, 8'h88) && !o) || (in_rng(c, 8'h8a, 8'hb7) && o) ||
                 (in_rng(c, 8'hb9, 8'hbe) && !o)) c--;
      8'hc6: if (c6_list(c)) c--;
      8'hc7:
        if (c == 8'h86 || c == 8'h89 || c == 8'h8c || c == 8'hb3) c -= 8'h02;
        else if (c == 8'h85 || c == 8'h88 || c == 8'h8b || c == 8'hb2 || c == 8'hb5 ||
                 c == 8'hb9 || c == 8'hbb || c == 8'hbd || c == 8'hbf) c--;
        else if ((in_rng(c, 8'h8d, 8'h9c) && !o) || (in_rng(c, 8'h9e, 8'haf) && o)) c--;
      8'hc8: if ((in_rng(c, 8'h80, 8'h9f) && o) || (in_rng(c, 8'ha2, 8'hb3) && o) ||
                 c == 8'hbc) c--;
      8'hcd:
        if (c == 8'hb1 || c == 8'hb3 || c == 8'hb7) c--;
        else if (in_rng(c, 8'hbb, 8'hbd)) begin l = 8'hcf; c += 8'h02; end
      8'hce:
        if (c == 8'hac) c = 8'h86;
        else if (in_rng(c, 8'had, 8'haf)) c -= 8'h25;
        else if (in_rng(c, 8'hb1, 8'hbf)) c -= 8'h20;
      8'hcf:
        if (c == 8'h97) c = 8'h8f;
        else if (c == 8'h91) begin l = 8'hce; c = 8'h98; end
        else if ((in_rng(c, 8'h98, 8'haf) && o) || c == 8'hb8 || c == 8'hbb) c--;
        else if (c == 8'hb2) c = 8'hb9;
        else if (c == 8'h8c) l = 8'hce;
        else if (c == 8'h8d || c == 8'h8e) begin l = 8'hce; c++; end
        else if (in_rng(c, 8'h80, 8'h8b) && c != 8'h82) begin l = 8'hce; c += 8'h20; end
        else if (c == 8'hb3) begin l = 8'hcd; c = 8'hbf; end
      8'hd0: if (in_rng(c, 8'hb0, 8'hbf)) c -= 8'h20;
      8'hd1:
        if (in_rng(c, 8'h80, 8'h8f)) begin l = 8'hd0; c += 8'h20; end
        else if (in_rng(c, 8'h90, 8'h9f)) begin l = 8'hd0; c -= 8'h10; end
        else if (in_rng(c, 8'ha0, 8'hbf) && o) c--;
      8'hd2:
        if (c == 8'h81) c = 8'h80;
        else if (in_rng(c, 8'h8a, 8'hbf) && o) c--;
      8'hd3: if ((in_rng(c, 8'h81, 8'h8e) && !o) || (in_rng(c, 8'h90, 8'hbf) && o)) c--;
      8'hd4: if (in_rng(c, 8'h80, 8'haf) && o) c--;
      8'hd5:
        if (in_rng(c, 8'ha1, 8'haf)) begin l = 8'hd4; c += 8'h10; end
        else if (in_rng(c, 8'hb0, 8'hbf)) c -= 8'h30;
      8'hd6: if (in_rng(c, 8'h80, 8'h86)) begin l = 8'hd5; c += 8'h10; end
      default: ;
    endcase
  endfunction

  // Two-byte lowercase rules, the inverse of the above.
  function automatic void lower2(inout logic [7:0] l, inout logic [7:0] c);
    logic o;
    o = c[0];
    case (l)
      8'hc3: if (in_rng(c, 8'h80, 8'h9e) && c != 8'h97) c += 8'h20;
      8'hc4:
        if ((in_rng(c, 8'h80, 8'hb7) && !o) || (in_rng(c, 8'hb9, 8'hbe) && o)) c++;
        else if (c == 8'hbf) begin l = 8'hc5; c = 8'h80; end
      8'hc5: if ((in_rng(c, 8'h81, 8'h88) && o) || (in_rng(c, 8'h8a, 8'hb7) && !o) ||
                 (in_rng(c, 8'hb9, 8'hbe) && o)) c++;
      8'hc6: if (c6_list(c + 8'h01)) c++;
      8'hc7:
        if (c == 8'h84 || c == 8'h87 || c == 8'h8a || c == 8'hb1) c += 8'h02;
        else if (c == 8'h85 || c == 8'h88 || c == 8'h8b || c == 8'hb2 || c == 8'hb4 ||
                 c == 8'hb8 || c == 8'hba || c == 8'hbc || c == 8'hbe) c++;
        else if ((in_rng(c, 8'h8d, 8'h9c) && o) || (in_rng(c, 8'h9e, 8'haf) && !o)) c++;
      8'hc8: if ((in_rng(c, 8'h80, 8'h9f) && !o) || (in_rng(c, 8'ha2, 8'hb3) && !o) ||
                 c == 8'hbb) c++;
      8'hcd:
        if (c == 8'hb0 || c == 8'hb2 || c == 8'hb6) c++;
        else if (c == 8'hbf) begin l = 8'hcf; c = 8'hb3; end
      8'hce:
        if (c == 8'h86) c = 8'hac;
        else if (in_rng(c, 8'h88, 8'h8a)) c += 8'h25;
        else if (c == 8'h8c) l = 8'hcf;
        else if (c == 8'h8e || c == 8'h8f) begin l = 8'hcf; c--; end
        else if (in_rng(c, 8'h91, 8'h9f)) c += 8'h20;
        else if (in_rng(c, 8'ha0, 8'hab) && c != 8'ha2) begin l = 8'hcf; c -= 8'h20; end
      8'hcf:
        if (c == 8'h8f) c = 8'h97;
        else if ((in_rng(c, 8'h98, 8'haf) && !o) || c == 8'hb7 || c == 8'hba) c++;
        else if (c == 8'hb9) c = 8'hb2;
        else if (in_rng(c, 8'hbd, 8'hbf)) begin l = 8'hcd; c -= 8'h02; end
      8'hd0:
        if (in_rng(c, 8'h80, 8'h8f)) begin l = 8'hd1; c += 8'h10; end
        else if (in_rng(c, 8'h90, 8'h9f)) c += 8'h20;
        else if (in_rng(c, 8'ha0, 8'haf)) begin l = 8'hd1; c -= 8'h20; end
      8'hd1: if (in_rng(c, 8'ha0, 8'hbf) && !o) c++;
      8'hd2:
        if (c == 8'h80) c = 8'h81;
        else if (in_rng(c, 8'h8a, 8'hbf) && !o) c++;
      8'hd3: if ((in_rng(c, 8'h81, 8'h8d) && o) || (in_rng(c, 8'h90, 8'hbf) && !o)) c++;
      8'hd4:
        if (in_rng(c, 8'h80, 8'haf) && !o) c++;
        else if (in_rng(c, 8'hb1, 8'hbf)) begin l = 8'hd5; c -= 8'h10; end
      8'hd5:
        if (in_rng(c, 8'h80, 8'h8f)) c += 8'h30;
        else if (in_rng(c, 8'h90, 8'h96)) begin l = 8'hd6; c -= 8'h10; end
      default: ;
    endcase
  endfunction

  // E1-led three-byte rules: s second byte, c third byte.
  function automatic void case3(logic up, inout logic [7:0] s, inout logic [7:0] c);
    if (up) begin
      case (s)
        8'h83:
          if (in_rng(c, 8'h90, 8'haf)) begin s = 8'h82; c += 8'h10; end
          else if (in_rng(c, 8'hb0, 8'hb5) || c == 8'hb7 || c == 8'hbd) c -= 8'h30;
        8'hb8, 8'hb9, 8'hbb: if (in_rng(c, 8'h80, 8'hbf) && c[0]) c--;
        8'hba: if ((in_rng(c, 8'h80, 8'h95) || in_rng(c, 8'ha0, 8'hbf)) && c[0]) c--;
        8'hbc, 8'hbd: if (in_rng(c, 8'h80, 8'hbf) && !c[3]) c += 8'h08;
        8'hbe: if (in_rng(c, 8'h80, 8'hb1) && !c[3]) c += 8'h08;
        8'hbf: if (in_rng(c, 8'h80, 8'h84) || in_rng(c, 8'h90, 8'h93) ||
                   in_rng(c, 8'ha0, 8'ha4)) c += 8'h08;
        default: ;
      endcase
    end else begin
      case (s)
        8'h82: if (in_rng(c, 8'ha0, 8'hbf)) begin s = 8'h83; c -= 8'h10; end
        8'h83: if (in_rng(c, 8'h80, 8'h85) || c == 8'h87 || c == 8'h8d) c += 8'h30;
        8'hb8, 8'hb9, 8'hbb: if (in_rng(c, 8'h80, 8'hbf) && !c[0]) c++;
        8'hba: if ((in_rng(c, 8'h80, 8'h95) || in_rng(c, 8'ha0, 8'hbf)) && !c[0]) c++;
        8'hbc, 8'hbd: if (in_rng(c, 8'h80, 8'hbf) && c[3]) c -= 8'h08;
        8'hbe: if (in_rng(c, 8'h80, 8'hb9) && c[3]) c -= 8'h08;
        8'hbf: if (in_rng(c, 8'h88, 8'h8c) || in_rng(c, 8'h98, 8'h9b) ||
                   in_rng(c, 8'ha8, 8'hac)) c -= 8'h08;
        default: ;
      endcase
    end
  endfunction

  // Osage and Adlam four-byte rules.
  function automatic void case4(logic up, logic [7:0] s, inout logic [7:0] t,
                                inout logic [7:0] c);
    if (s == OSAGE_2ND) begin
      if (up) begin
        if (t == 8'h93 && in_rng(c, 8'h98, 8'ha7)) begin t = 8'h92; c += 8'h18; end
        else if (t == 8'h93 && in_rng(c, 8'ha8, 8'hbb)) c -= 8'h28;
      end else begin
        if (t == 8'h92 && in_rng(c, 8'hb0, 8'hbf)) begin t = 8'h93; c -= 8'h18; end
        else if (t == 8'h93 && in_rng(c, 8'h80, 8'h93)) c += 8'h28;
      end
    end else if (s == ADLAM_2ND) begin
      if (up) begin
        if (t == 8'ha4 && in_rng(c, 8'ha2, 8'hbf)) c -= 8'h22;
        else if (t == 8'ha5 && in_rng(c, 8'h80, 8'h83)) begin t = 8'ha4; c += 8'h1e; end
      end else begin
        if (t == 8'ha4 && in_rng(c, 8'h80, 8'h9d)) c += 8'h22;
        else if (t == 8'ha4 && in_rng(c, 8'h9e, 8'ha1)) begin t = 8'ha5; c -= 8'h1e; end
      end
    end
  endfunction

  // Queue n converted bytes and close any open sequence.
  function automatic void release_bytes(logic [7:0] seq[4], int n, logic last);
    conv_byte_t e;
    for (int k = 0; k < n; k++) begin
      e.data = seq[k];
      e.run_end = (k == n - 1);
      e.string_end = last && (k == n - 1);
      expected_bytes.push_back(e);
    end
    path = P_NONE;
    held_n = 0;
    if (last) stopped = 1'b0;
  endfunction

  // Advance the predictor by one accepted request.
  function automatic void predict_byte(logic [7:0] b, logic last);
    logic [7:0] seq[4];
    int         n;
    if (stopped || path == P_NONE) begin
      path = P_NONE;
      held_n = 0;
      if (!stopped) begin
        if (b == 8'h00) begin
          stopped = 1'b1;
        end else if (b > 8'hc0 && !last) begin
          held[0] = b;
          held_n = 1;
          path = (b == 8'he1) ? P_E1 : (b == 8'hf0) ? P_F0 : P_TWO;
          return;
        end else if (mode_upper && in_rng(b, 8'h61, 8'h7a)) begin
          b -= 8'h20;
        end else if (!mode_upper && in_rng(b, 8'h41, 8'h5a)) begin
          b += 8'h20;
        end
      end
      seq[0] = b;
      release_bytes(seq, 1, last);
      return;
    end
    n = held_n;
    for (int k = 0; k < n; k++) seq[k] = held[k];
    seq[n] = b;
    n++;
    case (path)
      P_TWO: begin
        if (mode_upper) upper2(seq[0], seq[1]); else lower2(seq[0], seq[1]);
        release_bytes(seq, n, last);
        return;
      end
      P_E1_MID: begin
        case3(mode_upper, seq[1], seq[2]);
        release_bytes(seq, n, last);
        return;
      end
      P_F0_MID: if (seq[1] != OSAGE_2ND && seq[1] != ADLAM_2ND) begin
        release_bytes(seq, n, last);
        return;
      end
      P_F0_TAIL: begin
        case4(mode_upper, seq[1], seq[2], seq[3]);
        release_bytes(seq, n, last);
        return;
      end
      default: ;
    endcase
    if (last || n > 3) begin
      release_bytes(seq, n, last);
      return;
    end
    held[n - 1] = b;
    held_n = n;
    path = seq_path_e'(path + 3'd1);
  endfunction

  // Send one request; idle first at the sender's current rate. Push stays high
  // after the accepting edge until the next request or a drain drives it.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(b, last);
  endtask

  task automatic send_string(logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Drop push, then wait until every expected byte has come, plus the pipeline tail.
  task automatic drain();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(logic up);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= up;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_upper = up;
  endtask

  // Random continuation byte, sometimes out of the 80..bf window.
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(8'hbf, 8'h80));
  endfunction

  // Build one random string, mostly well formed.
  function automatic void rand_string(ref logic [7:0] s[$]);
    int len;
    int kind;
    s.delete();
    len = $urandom_range(6, 1);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(9);
      case (kind)
        0: s.push_back(8'($urandom_range(255)));
        1: s.push_back(8'($urandom_range(8'h7a, 8'h41)));
        2, 3: begin
          s.push_back(8'($urandom_range(8'hd6, 8'hc1)));
          s.push_back(cont_byte());
        end
        4, 5: begin
          s.push_back(8'he1);
          s.push_back($urandom_range(1) ? 8'($urandom_range(8'hbf, 8'hb8)) :
                      8'($urandom_range(8'h83, 8'h82)));
          s.push_back(cont_byte());
        end
        6, 7: begin
          s.push_back(8'hf0);
          s.push_back($urandom_range(3) == 0 ? cont_byte() :
                      ($urandom_range(1) ? OSAGE_2ND : ADLAM_2ND));
          s.push_back($urandom_range(1) ? 8'($urandom_range(8'h93, 8'h92)) :
                      8'($urandom_range(8'ha5, 8'ha4)));
          s.push_back(cont_byte());
        end
        8: s.push_back(8'h00);
        default: s.push_back(8'($urandom_range(8'hff, 8'hd7)));
      endcase
    end
    // Drop a tail byte now and then to leave a truncated sequence.
    if (s.size() > 1 && $urandom_range(7) == 0) void'(s.pop_back());
  endfunction

  // Directed: extremes, ASCII, each script, zero stop, truncation.
  task automatic test_directed();
    send_string('{8'h00, 8'h61, 8'hc3, 8'ha9});
    send_string('{8'hff});
    send_string('{8'h61, 8'h7a, 8'h41, 8'h5a, 8'h7f});
    send_string('{8'hc3, 8'ha0, 8'hd1, 8'h80, 8'hc5, 8'h80});
    send_string('{8'he1, 8'h83, 8'h90, 8'he1, 8'hbc, 8'h80});
    send_string('{8'hf0, 8'h90, 8'h93, 8'ha8, 8'hf0, 8'h9e, 8'ha4, 8'ha2});
    send_string('{8'hf0, 8'h9f, 8'h98});
    send_string('{8'he1, 8'h83});
    send_string('{8'hc1});
  endtask

  task automatic test_lowercase();
    set_mode(1'b0);
    send_string('{8'h41, 8'h5a, 8'hc3, 8'h80, 8'hd0, 8'h80, 8'hce, 8'ha0});
    send_string('{8'he1, 8'h82, 8'ha0, 8'hf0, 8'h90, 8'h92, 8'hb0});
    send_string('{8'hf0, 8'h9e, 8'ha4, 8'h9e});
    // Mode change in the middle of a sequence: completing byte's mode wins.
    send_byte(8'hc3, 1'b0);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_upper = 1'b1;
    send_byte(8'ha9, 1'b1);
  endtask

  task automatic test_random(int n_items);
    logic [7:0] s[$];
    int         sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(15) == 0) set_mode(1'($urandom_range(1)));
      rand_string(s);
      send_string(s);
      sent += s.size();
      // Hold off once until the output has fully drained.
      if (sent > n_items / 2 && sent - s.size() <= n_items / 2) drain();
    end
  endtask

  // Result side: random stall and a field-by-field compare.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output byte %h run_end %b string_end %b",
                   out_byte, out_run_end, out_string_end);
      end else begin
        conv_byte_t e;
        e = expected_bytes.pop_front();
        if (out_byte !== e.data || out_run_end !== e.run_end ||
            out_string_end !== e.string_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b got %h/%b/%b", e.data, e.run_end,
                     e.string_end, out_byte, out_run_end, out_string_end);
        end
      end
    end
    pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 19;
    recv_idle_pct = 59;
    test_directed();
    test_lowercase();
    set_mode(1'b1);
    test_random(170);
    send_idle_pct = 59;
    recv_idle_pct = 19;
    test_random(170);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_mode(1'b0);
    test_random(170);
    drain();
    if (mismatches == 0 && expected_bytes.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
